// File: rtl/core/hdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdu_pkg : shared types and constants of the half-duplex 8N1 uart
// Operation codes, transceiver modes, configuration indexes and the result
// record passed from the bit engine to the output stage.
// ----------------------------------------------------------------------------
package hdu_pkg;

	// request codes carried by the op field
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SEND = 2'd1,
		OP_RECV = 2'd2,
		OP_RSVD = 2'd3
	} op_t;

	// transceiver modes
	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_TX      = 2'd1,
		MODE_RX_WAIT = 2'd2,
		MODE_RX_DATA = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic CFG_HALF_BIT_TICKS   = 1'b0;
	localparam logic CFG_RX_TIMEOUT_TICKS = 1'b1;

	localparam logic [15:0] HALF_BIT_TICKS_RST   = 16'd69;
	localparam logic [15:0] RX_TIMEOUT_TICKS_RST = 16'hffff;

	// frame geometry in half-bits
	localparam logic [4:0] FRAME_HALF_BITS = 5'd20;
	localparam logic [4:0] STOP_HALF_BIT   = 5'd18;
	localparam logic [4:0] FIRST_SAMPLE_HB = 5'd3;
	localparam logic [4:0] LAST_SAMPLE_HB  = 5'd17;

	localparam logic [7:0] FRAMING_ERROR_BYTE = 8'd62;

	// one result of a tick
	typedef struct packed {
		logic       tx_line;
		logic       busy_res;
		logic       rx_done;
		logic [7:0] rx_byte;
		logic       frame_error;
		logic       timed_out;
	} result_t;

endpackage

// File: rtl/core/half_duplex_uart_8n1.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1 : half-duplex 8N1 uart on a half-bit tick timer
// Each accepted tick's result is registered in the output stage.
// Throughput: one tick per cycle; a two-entry output stage keeps taking
// ticks while one result waits, and stalls input only when both are full.
// Reset: asynchronous, active low; engine line high, timing regs at defaults.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1
	import hdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	// input tick channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  tx_byte,
	input  logic        rx_line,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_line,
	output logic        busy_res,
	output logic        rx_done,
	output logic [7:0]  rx_byte,
	output logic        frame_error,
	output logic        timed_out
);

	logic [15:0] half_bit_ticks_q;
	logic [15:0] rx_timeout_ticks_q;
	result_t     res;
	result_t     out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        in_xfer, out_xfer, out_free;

	assign in_ready = !skid_valid_q;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign out_free = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_ticks_q   <= HALF_BIT_TICKS_RST;
			rx_timeout_ticks_q <= RX_TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_HALF_BIT_TICKS) begin
				half_bit_ticks_q <= cfg_wdata;
			end else begin
				rx_timeout_ticks_q <= cfg_wdata;
			end
		end
	end

	hdu_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (in_xfer),
		.op               (op),
		.tx_byte          (tx_byte),
		.rx_line          (rx_line),
		.half_bit_ticks   (half_bit_ticks_q),
		.rx_timeout_ticks (rx_timeout_ticks_q),
		.res              (res)
	);

	// output stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= in_xfer;
			end else begin
				out_valid_q  <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output stage payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (in_xfer) begin
					skid_q <= res;
				end
			end else if (in_xfer) begin
				out_q <= res;
			end
		end else if (in_xfer) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign tx_line     = out_q.tx_line;
	assign busy_res    = out_q.busy_res;
	assign rx_done     = out_q.rx_done;
	assign rx_byte     = out_q.rx_byte;
	assign frame_error = out_q.frame_error;
	assign timed_out   = out_q.timed_out;

	// skid entry only holds a result behind a waiting one
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a finished receive is never reported as still busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rx_done) |-> !busy_res)
		else $error("receive finished while busy");

	// framing error carries the marker byte and ends a receive
	a_ferr_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_error) |-> (rx_done && (rx_byte == FRAMING_ERROR_BYTE)
			&& !timed_out))
		else $error("framing error without marker byte");

	// timeout gives an empty byte and ends a receive
	a_timeout_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timed_out) |-> (rx_done && (rx_byte == 8'd0)))
		else $error("timeout with non-zero byte");

endmodule

// File: rtl/core/hdu_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdu_engine : bit engine of the half-duplex 8N1 uart
// Holds the transceiver state, works out the next state and the result of
// the presented tick, and commits the state on each input transfer.
// ----------------------------------------------------------------------------
module hdu_engine
	import hdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  op,
	input  logic [7:0]  tx_byte,
	input  logic        rx_line,
	input  logic [15:0] half_bit_ticks,
	input  logic [15:0] rx_timeout_ticks,
	output result_t     res
);

	mode_t       mode_q,       mode_d;
	logic [15:0] tick_count_q, tick_count_d;
	logic [4:0]  half_bits_q,  half_bits_d;
	logic [2:0]  bit_index_q,  bit_index_d;
	logic [7:0]  shift_byte_q, shift_byte_d;
	logic [15:0] wait_count_q, wait_count_d;
	logic        line_out_q,   line_out_d;

	logic [15:0] tick_inc;
	logic        hb_end;
	logic [4:0]  hb_inc;
	logic [15:0] wait_inc;
	logic        done, ferr, tout;
	logic [7:0]  byte_res;

	// half-bit timer
	always_comb begin
		tick_inc = tick_count_q + 16'd1;
		hb_end   = (tick_inc >= half_bit_ticks) || (tick_inc == 16'd0);
		hb_inc   = half_bits_q + 5'd1;
		wait_inc = wait_count_q + 16'd1;
	end

	// next state and result
	always_comb begin
		mode_d       = mode_q;
		tick_count_d = tick_count_q;
		half_bits_d  = half_bits_q;
		bit_index_d  = bit_index_q;
		shift_byte_d = shift_byte_q;
		wait_count_d = wait_count_q;
		line_out_d   = line_out_q;
		done         = 1'b0;
		ferr         = 1'b0;
		tout         = 1'b0;
		byte_res     = 8'd0;
		case (mode_q)
			MODE_IDLE: begin
				if (op == OP_SEND) begin
					mode_d       = MODE_TX;
					shift_byte_d = tx_byte;
					line_out_d   = 1'b0;
					tick_count_d = 16'd0;
					half_bits_d  = 5'd0;
					bit_index_d  = 3'd0;
				end else if (op == OP_RECV) begin
					mode_d       = MODE_RX_WAIT;
					wait_count_d = 16'd0;
				end
			end
			MODE_TX: begin
				tick_count_d = hb_end ? 16'd0 : tick_inc;
				if (hb_end) begin
					half_bits_d = hb_inc;
					if (!hb_inc[0]) begin
						if (hb_inc >= FRAME_HALF_BITS) begin
							mode_d     = MODE_IDLE;
							line_out_d = 1'b1;
						end else if (hb_inc == STOP_HALF_BIT) begin
							line_out_d = 1'b1;
						end else begin
							line_out_d  = shift_byte_q[bit_index_q];
							bit_index_d = bit_index_q + 3'd1;
						end
					end
				end
			end
			MODE_RX_WAIT: begin
				if (!rx_line) begin
					mode_d       = MODE_RX_DATA;
					tick_count_d = 16'd0;
					half_bits_d  = 5'd0;
					bit_index_d  = 3'd0;
					shift_byte_d = 8'd0;
				end else begin
					wait_count_d = wait_inc;
					if ((wait_inc >= rx_timeout_ticks) || (wait_inc == 16'd0)) begin
						mode_d = MODE_IDLE;
						done   = 1'b1;
						tout   = 1'b1;
					end
				end
			end
			MODE_RX_DATA: begin
				tick_count_d = hb_end ? 16'd0 : tick_inc;
				if (hb_end) begin
					half_bits_d = hb_inc;
					if (hb_inc >= FRAME_HALF_BITS) begin
						mode_d = MODE_IDLE;
						done   = 1'b1;
						if (!rx_line) begin
							ferr     = 1'b1;
							byte_res = FRAMING_ERROR_BYTE;
						end else begin
							byte_res = shift_byte_q;
						end
					end else if (hb_inc[0] && (hb_inc >= FIRST_SAMPLE_HB)
							&& (hb_inc <= LAST_SAMPLE_HB)) begin
						shift_byte_d[bit_index_q] = shift_byte_q[bit_index_q] | rx_line;
						bit_index_d = bit_index_q + 3'd1;
					end
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		res.tx_line     = line_out_d;
		res.busy_res    = (mode_d != MODE_IDLE);
		res.rx_done     = done;
		res.rx_byte     = byte_res;
		res.frame_error = ferr;
		res.timed_out   = tout;
	end

	// state register, committed on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			tick_count_q <= 16'd0;
			half_bits_q  <= 5'd0;
			bit_index_q  <= 3'd0;
			shift_byte_q <= 8'd0;
			wait_count_q <= 16'd0;
			line_out_q   <= 1'b1;
		end else if (accept) begin
			mode_q       <= mode_d;
			tick_count_q <= tick_count_d;
			half_bits_q  <= half_bits_d;
			bit_index_q  <= bit_index_d;
			shift_byte_q <= shift_byte_d;
			wait_count_q <= wait_count_d;
			line_out_q   <= line_out_d;
		end
	end

endmodule
